/* src/satl_pkg.sv */
// Package for the set-associative cache tag lookup unit.
// Holds register codes, replacement modes, reset values and the LFSR step.
// No dependencies.
`default_nettype none

package satl_pkg;

  localparam int APB_AW = 4;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_BASE = 2'd1;
  localparam logic [1:0] REG_LEN  = 2'd2;

  localparam logic [1:0] MODE_LRU       = 2'd0;
  localparam logic [1:0] MODE_RAND      = 2'd1;
  localparam logic [1:0] MODE_PURE_RAND = 2'd2;

  localparam logic [31:0] REGION_BASE_RST = 32'hA000_0000;
  localparam logic [31:0] REGION_LEN_RST  = 32'h0400_0000;

  localparam logic [15:0] LFSR_SEED = 16'h0001;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef struct packed {
    logic hit;
    logic use_random;
    logic lru;
  } satl_pick_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] sh;
    sh = {1'b0, v[15:1]};
    return v[0] ? (sh ^ LFSR_TAPS) : sh;
  endfunction

endpackage

`default_nettype wire

/* src/satl_if.sv */
// Valid/ready channel interfaces for the tag lookup unit.
// satl_req_if carries fetch addresses, satl_rsp_if carries lookup results.
`default_nettype none

interface satl_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] addr;

  modport source (output valid, output addr, input ready);
  modport sink (input valid, input addr, output ready);
endinterface

interface satl_rsp_if;
  logic        valid;
  logic        ready;
  logic        in_region;
  logic        hit;
  logic [1:0]  way_used;
  logic [31:0] access_total;
  logic [31:0] hit_total;

  modport source (output valid, output in_region, output hit, output way_used,
                  output access_total, output hit_total, input ready);
  modport sink (input valid, input in_region, input hit, input way_used,
                input access_total, input hit_total, output ready);
endinterface

`default_nettype wire

/* src/satl_victim.sv */
// Tag compare and way selection for one set of the tag lookup unit.
// Depends on satl_pkg for the replacement mode codes and the pick struct.
`default_nettype none

module satl_victim import satl_pkg::*; #(
  parameter int WAYS = 4,
  parameter int TW   = 24,
  parameter int WW   = 2
) (
  input  logic [WAYS-1:0]    way_valid,
  input  logic [WAYS*TW-1:0] way_tags,
  input  logic [WAYS*WW-1:0] way_ages,
  input  logic [TW-1:0]      tag,
  input  logic [1:0]         mode,
  input  logic [WW-1:0]      rand_way,
  output satl_pick_t         pick,
  output logic [WW-1:0]      way
);

  logic          hit_found;
  logic [WW-1:0] hit_way;
  logic          empty_found;
  logic [WW-1:0] free_way;
  logic [WW-1:0] best_age;
  logic [WW-1:0] lru_way;

  always_comb begin
    hit_found   = 1'b0;
    hit_way     = '0;
    empty_found = 1'b0;
    free_way    = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit_found && way_valid[i] && way_tags[i*TW +: TW] == tag) begin
        hit_found = 1'b1;
        hit_way   = WW'(i);
      end
      if (!empty_found && !way_valid[i]) begin
        empty_found = 1'b1;
        free_way    = WW'(i);
      end
    end
  end

  always_comb begin
    best_age = way_ages[0 +: WW];
    lru_way  = '0;
    for (int i = 1; i < WAYS; i++) begin
      if (way_ages[i*WW +: WW] < best_age) begin
        best_age = way_ages[i*WW +: WW];
        lru_way  = WW'(i);
      end
    end
  end

  always_comb begin
    pick.hit        = hit_found;
    pick.use_random = 1'b0;
    pick.lru        = (mode != MODE_RAND) && (mode != MODE_PURE_RAND);
    way             = hit_way;
    if (!hit_found) begin
      if (mode == MODE_PURE_RAND) begin
        pick.use_random = 1'b1;
        way             = rand_way;
      end else if (empty_found) begin
        way = free_way;
      end else if (mode == MODE_RAND) begin
        pick.use_random = 1'b1;
        way             = rand_way;
      end else begin
        way = lru_way;
      end
    end
  end

endmodule

`default_nettype wire

/* src/set_assoc_cache_tag_lookup_unit.sv */
// Top level of the set-associative cache tag lookup unit.
// Depends on satl_pkg, satl_if and satl_victim.
//
// Channel  Direction  Beat contents
// req      in         addr
// rsp      out        in_region, hit, way_used, access_total, hit_total
// apb      in         repl_mode, region_base, region_len
//
// One address is taken per cycle unless stalled; s1 then out_* register it.
// The set row is read from memory at acceptance and compared in the next cycle.
// After reset a clearing pass over all 2**INDEX_BITS sets holds req.ready low.
// A stalled rsp holds the result register; once s1 is full, req.ready drops.
`default_nettype none

module set_assoc_cache_tag_lookup_unit import satl_pkg::*; #(
  parameter int OFFSET_BITS = 4,
  parameter int INDEX_BITS  = 4,
  parameter int WAYS        = 4
) (
  input  logic              clk,
  input  logic              rst,
  satl_req_if.sink          req,
  satl_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int NSETS = 1 << INDEX_BITS;
  localparam int SW    = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int TW    = 32 - OFFSET_BITS - INDEX_BITS;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RK    = 20;
  localparam logic [RK:0] RECIP    = (RK+1)'(((1 << RK) + WAYS - 1) / WAYS);
  localparam logic [16:0] WAYS_K   = 17'(WAYS);
  localparam logic [WW-1:0] AGE_TOP = WW'(WAYS - 1);
  localparam logic [SW-1:0] LAST_SET = SW'(NSETS - 1);

  logic [1:0]  repl_mode;
  logic [31:0] region_base;
  logic [31:0] region_len;

  logic          clearing;
  logic [SW-1:0] clr_idx;

  logic [WAYS-1:0]    mem_v   [NSETS];
  logic [WAYS*TW-1:0] mem_tag [NSETS];
  logic [WAYS*WW-1:0] mem_age [NSETS];

  logic [WAYS-1:0]    rd_v;
  logic [WAYS*TW-1:0] rd_tag;
  logic [WAYS*WW-1:0] rd_age;

  logic               fwd_valid;
  logic [SW-1:0]      fwd_set;
  logic [WAYS-1:0]    fwd_v;
  logic [WAYS*TW-1:0] fwd_tag;
  logic [WAYS*WW-1:0] fwd_age;

  logic          s1_valid;
  logic [31:0]   s1_addr;
  logic [SW-1:0] s1_set;

  logic [31:0] access_counter;
  logic [31:0] hit_counter;
  logic [15:0] lfsr_value;

  logic        out_valid;
  logic        out_in_region;
  logic        out_hit;
  logic [1:0]  out_way;
  logic [31:0] out_acc;
  logic [31:0] out_hits;

  logic          in_fire;
  logic          s1_adv;
  logic [SW-1:0] in_set;
  logic          cfg_we;

  logic [WAYS-1:0]    eff_v;
  logic [WAYS*TW-1:0] eff_tag;
  logic [WAYS*WW-1:0] eff_age;
  logic [WAYS-1:0]    new_v;
  logic [WAYS*TW-1:0] new_tag;
  logic [WAYS*WW-1:0] new_age;

  logic [TW-1:0]   s1_tag;
  logic [32:0]     region_end;
  logic            s1_in;
  logic            mem_we;
  logic [15:0]     lfsr_nx;
  logic [RK+16:0]  rand_prod;
  logic [16:0]     rand_q;
  logic [16:0]     rand_rem;
  logic [WW-1:0]   rand_way;
  satl_pick_t      pick;
  logic [WW-1:0]   pick_way;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !clearing && (!s1_valid || s1_adv);
  assign in_fire   = req.valid && req.ready;

  generate
    if (INDEX_BITS > 0) begin : g_set
      assign in_set = req.addr[OFFSET_BITS +: INDEX_BITS];
    end else begin : g_noset
      assign in_set = 1'b0;
    end
  endgenerate

  assign s1_tag     = s1_addr[31 -: TW];
  assign region_end = {1'b0, region_base} + {1'b0, region_len};
  assign s1_in      = (s1_addr >= region_base) && ({1'b0, s1_addr} < region_end);

  assign eff_v   = (fwd_valid && fwd_set == s1_set) ? fwd_v : rd_v;
  assign eff_tag = (fwd_valid && fwd_set == s1_set) ? fwd_tag : rd_tag;
  assign eff_age = (fwd_valid && fwd_set == s1_set) ? fwd_age : rd_age;

  assign lfsr_nx   = lfsr_step(lfsr_value);
  assign rand_prod = lfsr_nx * RECIP;
  assign rand_q    = rand_prod[RK+16:RK];
  assign rand_rem  = {1'b0, lfsr_nx} - 17'(rand_q * WAYS_K);
  assign rand_way  = rand_rem[WW-1:0];

  satl_victim #(
    .WAYS (WAYS),
    .TW   (TW),
    .WW   (WW)
  ) u_victim (
    .way_valid (eff_v),
    .way_tags  (eff_tag),
    .way_ages  (eff_age),
    .tag       (s1_tag),
    .mode      (repl_mode),
    .rand_way  (rand_way),
    .pick      (pick),
    .way       (pick_way)
  );

  always_comb begin
    new_v   = eff_v;
    new_tag = eff_tag;
    new_age = eff_age;
    if (!pick.hit) begin
      new_v[pick_way]              = 1'b1;
      new_tag[pick_way*TW +: TW]   = s1_tag;
    end
    if (pick.lru) begin
      for (int i = 0; i < WAYS; i++) begin
        if (WW'(i) == pick_way) begin
          new_age[i*WW +: WW] = AGE_TOP;
        end else if (eff_age[i*WW +: WW] != '0) begin
          new_age[i*WW +: WW] = eff_age[i*WW +: WW] - 1'b1;
        end
      end
    end
  end

  assign mem_we = s1_adv && s1_in;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem_v[clr_idx]   <= '0;
      mem_age[clr_idx] <= '0;
    end else if (mem_we) begin
      mem_v[s1_set]   <= new_v;
      mem_tag[s1_set] <= new_tag;
      mem_age[s1_set] <= new_age;
    end
    if (in_fire) begin
      rd_v   <= mem_v[in_set];
      rd_tag <= mem_tag[in_set];
      rd_age <= mem_age[in_set];
    end
  end

  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_MODE: prdata = {30'd0, repl_mode};
      REG_BASE: prdata = region_base;
      REG_LEN:  prdata = region_len;
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repl_mode      <= MODE_LRU;
      region_base    <= REGION_BASE_RST;
      region_len     <= REGION_LEN_RST;
      clearing       <= 1'b1;
      clr_idx        <= '0;
      fwd_valid      <= 1'b0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      access_counter <= '0;
      hit_counter    <= '0;
      lfsr_value     <= LFSR_SEED;
    end else begin
      if (cfg_we) begin
        case (paddr[3:2])
          REG_MODE: repl_mode   <= pwdata[1:0];
          REG_BASE: region_base <= pwdata;
          REG_LEN:  region_len  <= pwdata;
          default:  ;
        endcase
      end
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == LAST_SET) begin
          clearing <= 1'b0;
        end
      end
      if (mem_we) begin
        fwd_valid <= 1'b1;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        access_counter <= access_counter + 1'b1;
        hit_counter    <= hit_counter + 32'(pick.hit);
        if (pick.use_random) begin
          lfsr_value <= lfsr_nx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr <= req.addr;
      s1_set  <= in_set;
    end
    if (mem_we) begin
      fwd_set <= s1_set;
      fwd_v   <= new_v;
      fwd_tag <= new_tag;
      fwd_age <= new_age;
    end
    if (s1_adv) begin
      out_in_region <= s1_in;
      out_hit       <= s1_in && pick.hit;
      out_way       <= s1_in ? 2'(pick_way) : 2'd0;
      out_acc       <= s1_in ? access_counter + 1'b1 : access_counter;
      out_hits      <= (s1_in && pick.hit) ? hit_counter + 1'b1 : hit_counter;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.in_region    = out_in_region;
  assign rsp.hit          = out_hit;
  assign rsp.way_used     = out_way;
  assign rsp.access_total = out_acc;
  assign rsp.hit_total    = out_hits;

endmodule

`default_nettype wire

/* src/satl_check.sv */
// Port-level checks for the tag lookup unit, attached to the top level by bind.
// Depends on the top level's ports only.
`default_nettype none

module satl_check (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_in_region,
  input logic        rsp_hit,
  input logic [1:0]  rsp_way_used,
  input logic [31:0] rsp_access_total,
  input logic [31:0] rsp_hit_total
);

  logic        seen;
  logic [31:0] last_acc;
  logic [31:0] last_hit;
  logic        rsp_fire;

  assign rsp_fire = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (rsp_fire) begin
      seen <= 1'b1;
    end
    if (rsp_fire) begin
      last_acc <= rsp_access_total;
      last_hit <= rsp_hit_total;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("input accepted during the clearing pass");

  a_out_of_region: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_in_region |-> !rsp_hit && rsp_way_used == 2'd0)
    else $error("out-of-region result reports a hit or a way");

  a_totals_step: assert property (@(posedge clk) disable iff (rst)
    rsp_fire && seen |->
      rsp_access_total == last_acc + 32'(rsp_in_region) &&
      rsp_hit_total == last_hit + 32'(rsp_hit))
    else $error("totals do not follow the previous beat");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_access_total) && $stable(rsp_way_used))
    else $error("stalled result beat changed");

endmodule

bind set_assoc_cache_tag_lookup_unit satl_check u_satl_check (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_in_region    (rsp.in_region),
  .rsp_hit          (rsp.hit),
  .rsp_way_used     (rsp.way_used),
  .rsp_access_total (rsp.access_total),
  .rsp_hit_total    (rsp.hit_total)
);

`default_nettype wire
